/* src/keypad_scan_numeric_entry_top_assert.svh */
// ----------------------------------------------------------------------------
// Keypad entry assertion macros
// Concurrent check macros used by the keypad entry execution stage; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef KEYPAD_SCAN_NUMERIC_ENTRY_TOP_ASSERT_SVH
`define KEYPAD_SCAN_NUMERIC_ENTRY_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define KSE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("keypad entry check failed");
// next-cycle implication
`define KSE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("keypad entry check failed");
`else
`define KSE_ASSERT_NOW(lbl, ante, cons)
`define KSE_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* src/kse_pkg.sv */
// ----------------------------------------------------------------------------
// Keypad entry package
// Shared types, codes and the key decoder of the keypad numeric entry block.
// ----------------------------------------------------------------------------
package kse_pkg;

  localparam int unsigned ROW_COUNT = 4;
  localparam logic [1:0]  ROW_LAST  = 2'(ROW_COUNT - 1);
  localparam logic [1:0]  COL_MODE  = 2'd3;  // A/B/C/D column
  localparam logic [7:0]  TICK_MAX  = 8'd255;
  localparam logic [7:0]  MODE_CLR_TICKS = 8'd10;
  localparam logic [7:0]  LOCKOUT_RESET  = 8'd2;

  // input item kinds
  localparam logic ITEM_TICK = 1'b0;
  localparam logic ITEM_EDGE = 1'b1;

  // entry modes
  localparam logic [1:0] EM_NONE   = 2'd0;
  localparam logic [1:0] EM_RANGE  = 2'd1;
  localparam logic [1:0] EM_SINGLE = 2'd2;
  localparam logic [1:0] EM_DIST   = 2'd3;

  // awaiting phases
  localparam logic [1:0] AW_FIRST  = 2'd0;
  localparam logic [1:0] AW_SECOND = 2'd1;
  localparam logic [1:0] AW_SINGLE = 2'd2;

  // pending commands
  localparam logic [1:0] CMD_WAIT    = 2'd0;
  localparam logic [1:0] CMD_CONFIRM = 2'd1;
  localparam logic [1:0] CMD_CANCEL  = 2'd2;

  typedef enum logic [2:0] {
    KC_TICK,
    KC_DIGIT,
    KC_STAR,
    KC_HASH,
    KC_MODE,
    KC_IGNORE
  } key_class_t;

  typedef struct packed {
    logic       mode;
    logic [1:0] column;
  } kse_in_t;

  typedef struct packed {
    logic [1:0] row_drive;
    logic       key_accepted;
    logic [1:0] entry_mode;
    logic [1:0] awaiting;
    logic [1:0] pending_command;
    logic [1:0] digit_count;
    logic [7:0] angle_first;
    logic [7:0] angle_second;
    logic [7:0] distance_value;
    logic       start_pulse;
    logic       configure_pulse;
  } kse_out_t;

  typedef struct packed {
    key_class_t kind;
    logic [3:0] value;  // digit, or mode code for mode keys
  } kse_key_t;

  // classified item passed from front to back
  typedef struct packed {
    key_class_t kind;
    logic [3:0] value;
    logic [1:0] row_drive;
  } kse_item_t;

  // Layout 123A / 456B / 789C / *0#D
  function automatic kse_key_t decode_key(input logic [1:0] row, input logic [1:0] col);
    kse_key_t k;
    k.kind  = KC_IGNORE;
    k.value = '0;
    if (col == COL_MODE) begin
      if (row != ROW_LAST) begin
        k.kind  = KC_MODE;
        k.value = 4'(row) + 4'd1;
      end
    end else if (row == ROW_LAST) begin
      unique case (col)
        2'd0:    k.kind = KC_STAR;
        2'd1:    k.kind = KC_DIGIT;
        default: k.kind = KC_HASH;
      endcase
    end else begin
      k.kind  = KC_DIGIT;
      k.value = 4'(row) * 4'd3 + 4'(col) + 4'd1;
    end
    return k;
  endfunction

endpackage

/* src/kse_front.sv */
// ----------------------------------------------------------------------------
// Keypad entry front end
// Takes input words, owns the row scan counter and classifies column edges.
// ----------------------------------------------------------------------------
module kse_front
  import kse_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  kse_in_t   in_data,
  output logic      push_valid,
  input  logic      push_ready,
  output kse_item_t push_item
);

  logic [1:0] row_index_r, row_index_nxt;
  logic [1:0] prev_row;
  logic       accept;
  kse_key_t   key;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid && push_ready;

  // row driven before the latest tick
  assign prev_row = row_index_r - 2'd1;
  assign key      = decode_key(prev_row, in_data.column);

  // classify the word
  always_comb begin
    row_index_nxt = row_index_r;
    if (in_data.mode == ITEM_TICK) begin
      row_index_nxt  = (row_index_r == ROW_LAST) ? 2'd0 : row_index_r + 2'd1;
      push_item.kind = KC_TICK;
      push_item.value = '0;
    end else begin
      push_item.kind  = key.kind;
      push_item.value = key.value;
    end
    push_item.row_drive = row_index_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_index_r <= 2'd0;
    end else if (accept) begin
      row_index_r <= row_index_nxt;
    end
  end

endmodule

/* src/kse_queue.sv */
// ----------------------------------------------------------------------------
// Keypad entry queue
// Two-entry FIFO decoupling the classifier from the execution stage.
// ----------------------------------------------------------------------------
module kse_queue
  import kse_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  output logic      push_ready,
  input  kse_item_t push_item,
  output logic      pop_valid,
  input  logic      pop_ready,
  output kse_item_t pop_item
);

  kse_item_t  mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push, do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

/* src/kse_back.sv */
// ----------------------------------------------------------------------------
// Keypad entry execution stage
// Applies lockout, digit entry and the entry state machine; registers results.
// ----------------------------------------------------------------------------
`include "keypad_scan_numeric_entry_top_assert.svh"

module kse_back
  import kse_pkg::*;
#(
  parameter int unsigned DIGIT_SLOTS = 3
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [7:0] cfg_data,
  input  logic      pop_valid,
  output logic      pop_ready,
  input  kse_item_t pop_item,
  output logic      out_valid,
  input  logic      out_ready,
  output kse_out_t  out_data
);

  logic [7:0] lockout_r;
  logic [7:0] tick_r, tick_nxt;
  logic [3:0] digit_r   [DIGIT_SLOTS];
  logic [3:0] digit_nxt [DIGIT_SLOTS];
  logic [1:0] held_r, held_nxt;
  logic [1:0] mode_r, mode_nxt;
  logic [1:0] wait_r, wait_nxt;
  logic [1:0] cmd_r, cmd_nxt;
  logic [7:0] first_r, first_nxt;
  logic [7:0] second_r, second_nxt;
  logic [7:0] dist_r, dist_nxt;
  logic       accepted, start, configure;
  logic       take;
  logic [9:0] buf_value;
  logic       out_valid_r;
  kse_out_t   out_data_r;

  assign cfg_ready = 1'b1;
  assign pop_ready = !out_valid_r || out_ready;
  assign take      = pop_valid && pop_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // decimal value of the held digits
  always_comb begin
    buf_value = '0;
    for (int i = 0; i < DIGIT_SLOTS; i++) begin
      if (2'(i) < held_r) begin
        buf_value = 10'((buf_value << 3) + (buf_value << 1)) + 10'(digit_r[i]);
      end
    end
  end

  // entry state machine
  always_comb begin
    tick_nxt   = tick_r;
    held_nxt   = held_r;
    mode_nxt   = mode_r;
    wait_nxt   = wait_r;
    cmd_nxt    = cmd_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    dist_nxt   = dist_r;
    accepted   = 1'b0;
    start      = 1'b0;
    configure  = 1'b0;
    for (int i = 0; i < DIGIT_SLOTS; i++) begin
      digit_nxt[i] = digit_r[i];
    end

    case (pop_item.kind) inside
      KC_TICK: begin
        if (tick_r != TICK_MAX) tick_nxt = tick_r + 8'd1;
      end
      KC_MODE: begin
        mode_nxt   = pop_item.value[1:0];
        first_nxt  = '0;
        second_nxt = '0;
        dist_nxt   = '0;
        held_nxt   = '0;
        cmd_nxt    = CMD_WAIT;
        wait_nxt   = (pop_item.value[1:0] == EM_RANGE) ? AW_FIRST : AW_SINGLE;
        if (tick_r >= MODE_CLR_TICKS) tick_nxt = '0;
        accepted   = 1'b1;
      end
      KC_DIGIT, KC_STAR, KC_HASH: begin
        // command flag is latched even inside the lockout
        if (pop_item.kind == KC_STAR) cmd_nxt = CMD_CONFIRM;
        if (pop_item.kind == KC_HASH) cmd_nxt = CMD_CANCEL;
        if (tick_r >= lockout_r) begin
          accepted = 1'b1;
          tick_nxt = '0;
          if (pop_item.kind == KC_DIGIT) begin
            if (held_r < 2'(DIGIT_SLOTS)) begin
              for (int i = 0; i < DIGIT_SLOTS; i++) begin
                if (held_r == 2'(i)) digit_nxt[i] = pop_item.value;
              end
              held_nxt = held_r + 2'd1;
            end
          end else if (mode_r != EM_NONE) begin
            held_nxt = '0;
            cmd_nxt  = CMD_WAIT;
            if (pop_item.kind == KC_STAR) begin
              case (mode_r)
                EM_RANGE: begin
                  if (wait_r == AW_FIRST) begin
                    first_nxt = buf_value[7:0];
                    wait_nxt  = AW_SECOND;
                  end else if (wait_r == AW_SECOND) begin
                    second_nxt = buf_value[7:0];
                    wait_nxt   = AW_FIRST;
                    start      = 1'b1;
                  end
                end
                EM_SINGLE: begin
                  first_nxt = buf_value[7:0];
                  start     = 1'b1;
                end
                default: begin
                  dist_nxt = buf_value[7:0];
                  start    = 1'b1;
                end
              endcase
            end else begin
              configure = (mode_r == EM_RANGE);
            end
          end
        end
      end
      default: ;  // key D
    endcase
  end

  // lockout register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lockout_r <= LOCKOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      lockout_r <= cfg_data;
    end
  end

  // entry state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r   <= '0;
      held_r   <= '0;
      mode_r   <= EM_NONE;
      wait_r   <= AW_FIRST;
      cmd_r    <= CMD_WAIT;
      first_r  <= '0;
      second_r <= '0;
      dist_r   <= '0;
    end else if (take) begin
      tick_r   <= tick_nxt;
      held_r   <= held_nxt;
      mode_r   <= mode_nxt;
      wait_r   <= wait_nxt;
      cmd_r    <= cmd_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
      dist_r   <= dist_nxt;
    end
  end

  // digit slots, undefined until written
  always_ff @(posedge clk) begin
    if (take) begin
      for (int i = 0; i < DIGIT_SLOTS; i++) begin
        digit_r[i] <= digit_nxt[i];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r.row_drive       <= pop_item.row_drive;
      out_data_r.key_accepted    <= accepted;
      out_data_r.entry_mode      <= mode_nxt;
      out_data_r.awaiting        <= wait_nxt;
      out_data_r.pending_command <= cmd_nxt;
      out_data_r.digit_count     <= held_nxt;
      out_data_r.angle_first     <= first_nxt;
      out_data_r.angle_second    <= second_nxt;
      out_data_r.distance_value  <= dist_nxt;
      out_data_r.start_pulse     <= start;
      out_data_r.configure_pulse <= configure;
    end
  end

  // checks
  `KSE_ASSERT_NOW(a_pulse_excl, out_valid_r, !(out_data_r.start_pulse && out_data_r.configure_pulse))
  `KSE_ASSERT_NOW(a_held_range, 1'b1, held_r <= 2'(DIGIT_SLOTS))
  `KSE_ASSERT_NEXT(a_take_shows, take, out_valid_r)
  `KSE_ASSERT_NOW(a_tick_no_key, out_valid_r && out_data_r.start_pulse, out_data_r.key_accepted)

endmodule

/* src/keypad_scan_numeric_entry_top.sv */
// Keypad scan numeric entry, top level.
// A taken input word is held in the queue, then its result in the result register.
// Throughput: one word per cycle while out_ready stays high, set by the execution stage.
// The two-entry queue and the result register let input and output stall independently.
// Reset: synchronous, active low; clears the control state only; lockout_ticks returns to 2.
// ----------------------------------------------------------------------------
// Keypad scan numeric entry top
// Front classifier, queue and execution stage of the 4x4 keypad entry block.
// ----------------------------------------------------------------------------
module keypad_scan_numeric_entry_top
  import kse_pkg::*;
#(
  parameter int unsigned DIGIT_SLOTS = 3
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  kse_in_t    in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output kse_out_t   out_data
);

  logic      push_valid, push_ready;
  logic      pop_valid, pop_ready;
  kse_item_t push_item, pop_item;

  kse_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  kse_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  kse_back #(
    .DIGIT_SLOTS (DIGIT_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* dv/keypad_scan_numeric_entry_top_test.sv */
// ----------------------------------------------------------------------------
// Keypad scan numeric entry testbench
// Drives scan ticks and column edges into the keypad entry block and checks
// every status word against an in-bench model of the scanner and the entry
// state machine. Covers key decode, lockout, mode keys and stored values.
// ----------------------------------------------------------------------------
module keypad_scan_numeric_entry_top_test
  import kse_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          SLOTS       = 3;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int          RAND_WORDS  = 250;
  localparam int          PHASES      = 5;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [7:0] cfg_data;
  logic       in_valid;
  logic       in_ready;
  kse_in_t    in_data;
  logic       out_valid;
  logic       out_ready = 1'b0;
  kse_out_t   out_data;

  keypad_scan_numeric_entry_top #(
    .DIGIT_SLOTS (SLOTS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // bench model of the scanner and entry state
  logic [7:0] lockout;
  logic [1:0] drive_row;
  logic [7:0] scan_ticks;
  logic [3:0] digit_buf [SLOTS];
  logic [1:0] digit_cnt;
  logic [1:0] sel_mode;
  logic [1:0] await_ph;
  logic [1:0] cmd_pend;
  logic [7:0] ang_lo;
  logic [7:0] ang_hi;
  logic [7:0] dist_val;

  kse_out_t    status_q [$];
  int          words_sent = 0;
  int          err_cnt    = 0;
  bit          calm       = 1'b0;
  bit          valid_up   = 1'b0;
  int unsigned cycle_cnt  = 0;
  int          stall_left = 0;

  // 123A / 456B / 789C / *0#D
  function automatic kse_key_t key_at(logic [1:0] row, logic [1:0] col);
    kse_key_t k;
    k.kind  = KC_DIGIT;
    k.value = 4'd0;
    case ({row, col})
      4'h0: k.value = 4'd1;
      4'h1: k.value = 4'd2;
      4'h2: k.value = 4'd3;
      4'h4: k.value = 4'd4;
      4'h5: k.value = 4'd5;
      4'h6: k.value = 4'd6;
      4'h8: k.value = 4'd7;
      4'h9: k.value = 4'd8;
      4'hA: k.value = 4'd9;
      4'hD: k.value = 4'd0;
      4'h3: begin k.kind = KC_MODE; k.value = {2'b00, EM_RANGE};  end
      4'h7: begin k.kind = KC_MODE; k.value = {2'b00, EM_SINGLE}; end
      4'hB: begin k.kind = KC_MODE; k.value = {2'b00, EM_DIST};   end
      4'hC: k.kind = KC_STAR;
      4'hE: k.kind = KC_HASH;
      default: k.kind = KC_IGNORE;
    endcase
    return k;
  endfunction

  // decimal value of the held digits, low 8 bits
  function automatic logic [7:0] buffer_number();
    int unsigned acc = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (i < digit_cnt) acc = acc * 10 + digit_buf[i];
    end
    return acc[7:0];
  endfunction

  function automatic void reset_entry_model();
    lockout    = LOCKOUT_RESET;
    drive_row  = '0;
    scan_ticks = '0;
    digit_cnt  = '0;
    sel_mode   = EM_NONE;
    await_ph   = AW_FIRST;
    cmd_pend   = CMD_WAIT;
    ang_lo     = '0;
    ang_hi     = '0;
    dist_val   = '0;
    for (int i = 0; i < SLOTS; i++) digit_buf[i] = '0;
  endfunction

  // advance the model by one word and return the status it should produce
  function automatic kse_out_t step_entry(kse_in_t w);
    kse_out_t   r;
    kse_key_t   k;
    logic [7:0] v;
    r = '0;
    if (w.mode == ITEM_TICK) begin
      drive_row = drive_row + 2'd1;
      if (scan_ticks != TICK_MAX) scan_ticks = scan_ticks + 8'd1;
    end else begin
      // decode against the row driven before the latest tick
      k = key_at(drive_row - 2'd1, w.column);
      if (k.kind == KC_MODE) begin
        sel_mode  = k.value[1:0];
        ang_lo    = '0;
        ang_hi    = '0;
        dist_val  = '0;
        digit_cnt = '0;
        cmd_pend  = CMD_WAIT;
        await_ph  = (sel_mode == EM_RANGE) ? AW_FIRST : AW_SINGLE;
        if (scan_ticks >= MODE_CLR_TICKS) scan_ticks = '0;
        r.key_accepted = 1'b1;
      end else if (k.kind != KC_IGNORE) begin
        // command is latched even when the lockout blocks it
        if (k.kind == KC_STAR) cmd_pend = CMD_CONFIRM;
        if (k.kind == KC_HASH) cmd_pend = CMD_CANCEL;
        if (scan_ticks >= lockout) begin
          r.key_accepted = 1'b1;
          if (k.kind == KC_DIGIT) begin
            if (digit_cnt < SLOTS) begin
              digit_buf[digit_cnt] = k.value;
              digit_cnt = digit_cnt + 2'd1;
            end
          end else if (sel_mode != EM_NONE && cmd_pend == CMD_CONFIRM) begin
            v = buffer_number();
            if (sel_mode == EM_RANGE) begin
              if (await_ph == AW_FIRST) begin
                ang_lo   = v;
                await_ph = AW_SECOND;
              end else if (await_ph == AW_SECOND) begin
                ang_hi   = v;
                await_ph = AW_FIRST;
                r.start_pulse = 1'b1;
              end
            end else if (sel_mode == EM_SINGLE) begin
              ang_lo = v;
              r.start_pulse = 1'b1;
            end else begin
              dist_val = v;
              r.start_pulse = 1'b1;
            end
            digit_cnt = '0;
            cmd_pend  = CMD_WAIT;
          end else if (sel_mode != EM_NONE && cmd_pend == CMD_CANCEL) begin
            digit_cnt = '0;
            cmd_pend  = CMD_WAIT;
            if (sel_mode == EM_RANGE) r.configure_pulse = 1'b1;
          end
          scan_ticks = '0;
        end
      end
    end
    r.row_drive       = drive_row;
    r.entry_mode      = sel_mode;
    r.awaiting        = await_ph;
    r.pending_command = cmd_pend;
    r.digit_count     = digit_cnt;
    r.angle_first     = ang_lo;
    r.angle_second    = ang_hi;
    r.distance_value  = dist_val;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    err_cnt++;
    $display("%0t mismatch: %s", $realtime, msg);
  endtask

  task automatic field_check(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // result side: compare each taken status word with the oldest prediction
  always @(posedge clk) begin
    kse_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (status_q.size() == 0) begin
        report_mismatch("status word with none outstanding");
      end else begin
        want = status_q.pop_front();
        field_check("row_drive",       out_data.row_drive,       want.row_drive);
        field_check("key_accepted",    out_data.key_accepted,    want.key_accepted);
        field_check("entry_mode",      out_data.entry_mode,      want.entry_mode);
        field_check("awaiting",        out_data.awaiting,        want.awaiting);
        field_check("pending_command", out_data.pending_command, want.pending_command);
        field_check("digit_count",     out_data.digit_count,     want.digit_count);
        field_check("angle_first",     out_data.angle_first,     want.angle_first);
        field_check("angle_second",    out_data.angle_second,    want.angle_second);
        field_check("distance_value",  out_data.distance_value,  want.distance_value);
        field_check("start_pulse",     out_data.start_pulse,     want.start_pulse);
        field_check("configure_pulse", out_data.configure_pulse, want.configure_pulse);
      end
    end
  end

  // result side back-pressure, in bursts of random length
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 2);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk);
    $display("== FAIL ==");
    $finish;
  end

  // send one word; valid stays up unless a gap follows
  task automatic send_word(kse_in_t w);
    in_data  <= w;
    in_valid <= 1'b1;
    valid_up = 1'b1;
    do @(posedge clk); while (!in_ready);
    status_q.push_back(step_entry(w));
    words_sent++;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      valid_up = 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic send_tick();
    kse_in_t w;
    w.mode   = ITEM_TICK;
    w.column = 2'($urandom_range(0, 3));
    send_word(w);
  endtask

  // press the key at row/col: extra ticks, then ticks until that row was last driven
  task automatic press_key(logic [1:0] row, logic [1:0] col, int extra);
    kse_in_t w;
    repeat (extra) send_tick();
    while (drive_row != row + 2'd1) send_tick();
    w.mode   = ITEM_EDGE;
    w.column = col;
    send_word(w);
  endtask

  // hold the sender until every status word is back
  task automatic drain_results();
    if (valid_up) begin
      in_valid <= 1'b0;
      valid_up = 1'b0;
    end
    do @(posedge clk); while (status_q.size() != 0);
  endtask

  task automatic load_lockout(logic [7:0] v);
    drain_results();
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    lockout = v;
    cfg_valid <= 1'b0;
  endtask

  // reset lockout: commands without a mode, key D, mode key clearing the count
  task automatic test_power_on();
    press_key(2'd3, 2'd0, 0);   // '*' before any tick, blocked but latched
    press_key(2'd3, 2'd3, 0);   // D
    press_key(2'd1, 2'd1, 2);   // '5' with no mode
    press_key(2'd3, 2'd2, 2);   // '#' with no mode
    press_key(2'd1, 2'd3, 12);  // B with count past 10, clears it
    press_key(2'd1, 2'd0, 0);   // '4' blocked straight after
    press_key(2'd0, 2'd3, 0);   // A with a low count
    press_key(2'd0, 2'd0, 0);
  endtask

  // range mode: full buffer, 8-bit truncation, second value, cancel
  task automatic test_range_entry();
    press_key(2'd0, 2'd3, 0);   // A
    press_key(2'd0, 2'd0, 0);
    press_key(2'd0, 2'd1, 0);
    press_key(2'd0, 2'd2, 0);
    press_key(2'd2, 2'd2, 0);   // fourth digit dropped
    press_key(2'd3, 2'd0, 0);   // first = 123
    press_key(2'd2, 2'd2, 0);
    press_key(2'd2, 2'd2, 0);
    press_key(2'd2, 2'd2, 0);
    press_key(2'd3, 2'd0, 0);   // second = 999 truncated, start
    press_key(2'd3, 2'd2, 0);   // cancel in range mode
  endtask

  task automatic test_single_and_distance();
    press_key(2'd1, 2'd3, 0);   // B
    press_key(2'd3, 2'd0, 0);   // confirm on empty buffer
    press_key(2'd2, 2'd3, 0);   // C
    press_key(2'd3, 2'd1, 0);
    press_key(2'd1, 2'd0, 0);
    press_key(2'd3, 2'd0, 0);   // distance = 4
    press_key(2'd3, 2'd2, 0);   // cancel, no configure outside range
  endtask

  // largest lockout: counter saturates, then one key passes
  task automatic test_lockout_saturation();
    repeat (300) send_tick();
    press_key(2'd2, 2'd0, 0);   // passes at the saturated count
    press_key(2'd3, 2'd0, 0);   // blocked, confirm left pending
    press_key(2'd0, 2'd3, 0);
    press_key(2'd1, 2'd3, 12);
  endtask

  task automatic random_words(int n);
    kse_in_t w;
    repeat (n) begin
      w.mode   = 1'($urandom_range(0, 1));
      w.column = 2'($urandom_range(0, 3));
      send_word(w);
    end
  endtask

  // one entry: mostly a mode key, then one or two digit values, most with a command
  task automatic random_entry();
    int          nval;
    int          k;
    int          fin;
    logic [1:0]  mrow;
    mrow = 2'($urandom_range(0, 2));
    nval = 1;
    if ($urandom_range(0, 7) != 0) begin
      press_key(mrow, 2'd3, $urandom_range(0, 2));
      if (mrow == 2'd0) nval = 2;
    end
    repeat (nval) begin
      repeat ($urandom_range(0, 4)) begin
        k = $urandom_range(0, 9);
        if (k == 9) press_key(2'd3, 2'd1, $urandom_range(0, lockout + 1));
        else press_key(2'(k / 3), 2'(k % 3), $urandom_range(0, lockout + 1));
      end
      fin = $urandom_range(0, 9);
      if (fin < 7) press_key(2'd3, 2'd0, $urandom_range(0, lockout + 1));
      else if (fin < 9) press_key(2'd3, 2'd2, $urandom_range(0, lockout + 1));
    end
  endtask

  task automatic test_random_sessions();
    logic [7:0] lock_set [PHASES];
    int         stop_at;
    lock_set[0] = 8'd1;
    lock_set[1] = 8'd3;
    lock_set[2] = 8'd0;
    lock_set[3] = 8'($urandom_range(0, 6));
    lock_set[4] = 8'd2;
    for (int p = 0; p < PHASES; p++) begin
      load_lockout(lock_set[p]);
      // no idling in the middle phase and in the last one
      calm    = (p == 2) || (p == PHASES - 1);
      stop_at = words_sent + RAND_WORDS / PHASES;
      while (words_sent < stop_at) begin
        if ($urandom_range(0, 4) == 0) random_words($urandom_range(1, 6));
        else random_entry();
      end
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    reset_entry_model();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_power_on();
    load_lockout(8'd0);
    test_range_entry();
    test_single_and_distance();
    load_lockout(8'd255);
    test_lockout_saturation();
    test_random_sessions();

    drain_results();
    repeat (8) @(posedge clk);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
